@@ sv/srst_pkg.sv @@
`timescale 1ns / 1ps

package srst_pkg;

    // Table geometry and field widths
    localparam int SLOTS_DEF  = 16;
    localparam int ADDR_W     = 64;
    localparam int SIZE_W     = 33;
    localparam int RSIZE_W    = 32;
    localparam int PE_W       = 8;
    localparam int SLOT_OUT_W = 4;

    // Rounding to an eight byte multiple
    localparam logic [SIZE_W-1:0] ALIGN_MASK = SIZE_W'(7);

    // Request codes
    typedef enum logic [1:0] {
        REQ_REGISTER = 2'd0,
        REQ_RELEASE  = 2'd1,
        REQ_LOOKUP   = 2'd2,
        REQ_NONE     = 2'd3
    } req_t;

    // Result status codes
    typedef enum logic [2:0] {
        STAT_OK         = 3'd0,
        STAT_ZERO_SIZE  = 3'd1,
        STAT_NO_SLOT    = 3'd2,
        STAT_ALLOC_FAIL = 3'd3,
        STAT_NOT_FOUND  = 3'd4,
        STAT_LOCAL      = 3'd5
    } status_t;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    // One table entry as held in the slot memory
    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [SIZE_W-1:0] size;
    } slot_entry_t;

    // Outcome of checking one entry
    typedef struct packed {
        logic              hit;
        logic [ADDR_W-1:0] offset;
    } match_t;

    // Round a byte count up to a multiple of eight
    function automatic logic [SIZE_W-1:0] align_size(input logic [RSIZE_W-1:0] rsize);
        logic [SIZE_W-1:0] sum;
        begin
            sum = {1'b0, rsize} + ALIGN_MASK;
            return sum & ~ALIGN_MASK;
        end
    endfunction

endpackage

@@ sv/srst_slot_mem.sv @@
`timescale 1ns / 1ps

module srst_slot_mem
    import srst_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF,
    parameter int IDX_W = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IDX_W-1:0] rd_idx,
    output slot_entry_t      rd_data,
    output logic             rd_valid,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_idx,
    input  logic             wr_valid,
    input  slot_entry_t      wr_data
);

    slot_entry_t      slot_mem_reg [SLOTS];
    slot_entry_t      rd_data_reg;
    logic [SLOTS-1:0] valid_reg;
    logic             rd_valid_reg;

    // Entry storage, registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem_reg[wr_idx] <= wr_data;
        end
        rd_data_reg <= slot_mem_reg[rd_idx];
    end

    // Occupancy bits; a clear bit means a free slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= valid_reg[rd_idx];
            if (wr_en)
            begin
                valid_reg[wr_idx] <= wr_valid;
            end
        end
    end

    assign rd_data  = rd_data_reg;
    assign rd_valid = rd_valid_reg;

endmodule

@@ sv/srst_match.sv @@
`timescale 1ns / 1ps

module srst_match
    import srst_pkg::*;
(
    input  logic              find_free,
    input  logic [ADDR_W-1:0] addr,
    input  logic              entry_valid,
    input  slot_entry_t       entry,
    output match_t            res
);

    logic [ADDR_W:0] diff;

    // Borrow out of the subtract means addr lies below the start
    assign diff = {1'b0, addr} - {1'b0, entry.start};

    always_comb
    begin
        res.offset = diff[ADDR_W-1:0];
        if (find_free)
        begin
            res.hit = !entry_valid;
        end
        else
        begin
            res.hit = entry_valid && !diff[ADDR_W] &&
                      (diff[ADDR_W-1:0] < ADDR_W'(entry.size));
        end
    end

endmodule

@@ sv/shared_region_slot_table.sv @@
// Zero-size registers, local lookups and no-ops raise done in the cycle after accept;
// otherwise the table is walked slot by slot until a slot matches or the last slot is checked.
// New transactions are accepted only while idle; the slot scan reads one memory entry a cycle.
// The receiver cannot stall: done is high for exactly one cycle per accepted transaction.
// Reset (asynchronous, active low) marks every slot free and clears the total, last_start and my_pe at once;
// no clearing pass is needed.
`timescale 1ns / 1ps

module shared_region_slot_table
    import srst_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            req_type,
    input  logic [RSIZE_W-1:0]    request_size,
    input  logic [ADDR_W-1:0]     address,
    input  logic [PE_W-1:0]       target_pe,
    output logic                  done,
    output logic [2:0]            status,
    output logic [SLOT_OUT_W-1:0] slot_index,
    output logic [ADDR_W-1:0]     offset,
    output logic [SIZE_W-1:0]     aligned_size,
    output logic [ADDR_W-1:0]     shared_total,
    output logic [ADDR_W-1:0]     last_start,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [PE_W-1:0]       cfg_data
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    // Control state
    state_t               state_reg, state_next;
    logic [IDX_W-1:0]     scan_idx_reg, scan_idx_next;
    logic                 chk_pend_reg, chk_pend_next;
    logic [IDX_W-1:0]     chk_idx_reg, chk_idx_next;
    logic                 found_reg, found_next;
    logic                 done_reg, done_next;
    logic [ADDR_W-1:0]    total_reg, total_next;
    logic [ADDR_W-1:0]    recent_reg, recent_next;
    logic [PE_W-1:0]      my_pe_reg, my_pe_next;

    // Transaction payload
    req_t                 req_reg, req_next;
    logic [ADDR_W-1:0]    addr_reg, addr_next;
    logic [SIZE_W-1:0]    asize_reg, asize_next;
    logic [IDX_W-1:0]     hit_idx_reg, hit_idx_next;
    logic [SIZE_W-1:0]    hit_size_reg, hit_size_next;
    logic [ADDR_W-1:0]    hit_off_reg, hit_off_next;
    status_t              status_reg, status_next;
    logic [SLOT_OUT_W-1:0] slot_reg, slot_next;
    logic [ADDR_W-1:0]    offset_reg, offset_next;

    // Memory and match wiring
    slot_entry_t          rd_entry;
    logic                 rd_valid;
    logic                 wr_en;
    logic                 wr_valid;
    slot_entry_t          wr_data;
    match_t               mres;

    req_t                 req_in;
    logic                 accept;
    logic                 needs_scan;

    assign req_in    = req_t'(req_type);
    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    // my_pe only changes with no transaction being taken in the same cycle
    assign cfg_ready = !busy && !start;

    // Decide at accept whether the table has to be walked
    always_comb
    begin
        unique case (req_in)
            REQ_REGISTER: needs_scan = (request_size != '0);
            REQ_RELEASE:  needs_scan = 1'b1;
            REQ_LOOKUP:   needs_scan = (target_pe != my_pe_reg);
            default:      needs_scan = 1'b0;
        endcase
    end

    srst_slot_mem #(
        .SLOTS (SLOTS),
        .IDX_W (IDX_W)
    ) u_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_idx   (scan_idx_reg),
        .rd_data  (rd_entry),
        .rd_valid (rd_valid),
        .wr_en    (wr_en),
        .wr_idx   (hit_idx_reg),
        .wr_valid (wr_valid),
        .wr_data  (wr_data)
    );

    srst_match u_match (
        .find_free   (req_reg == REQ_REGISTER),
        .addr        (addr_reg),
        .entry_valid (rd_valid),
        .entry       (rd_entry),
        .res         (mres)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && needs_scan)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (chk_pend_reg && (mres.hit || chk_idx_reg == LAST_IDX))
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        scan_idx_next = scan_idx_reg;
        chk_pend_next = chk_pend_reg;
        chk_idx_next  = chk_idx_reg;
        found_next    = found_reg;
        done_next     = 1'b0;
        total_next    = total_reg;
        recent_next   = recent_reg;
        my_pe_next    = (cfg_valid && cfg_ready) ? cfg_data : my_pe_reg;
        req_next      = req_reg;
        addr_next     = addr_reg;
        asize_next    = asize_reg;
        hit_idx_next  = hit_idx_reg;
        hit_size_next = hit_size_reg;
        hit_off_next  = hit_off_reg;
        status_next   = status_reg;
        slot_next     = slot_reg;
        offset_next   = offset_reg;
        wr_en         = 1'b0;
        wr_valid      = 1'b0;
        wr_data       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    req_next      = req_in;
                    addr_next     = address;
                    asize_next    = (req_in == REQ_REGISTER) ? align_size(request_size) : '0;
                    scan_idx_next = '0;
                    chk_pend_next = 1'b0;
                    found_next    = 1'b0;
                    hit_idx_next  = '0;
                    // Answers that need no table walk
                    if (!needs_scan)
                    begin
                        done_next = 1'b1;
                        slot_next = '0;
                        unique case (req_in)
                            REQ_REGISTER:
                            begin
                                status_next = STAT_ZERO_SIZE;
                                offset_next = '0;
                            end
                            REQ_LOOKUP:
                            begin
                                status_next = STAT_LOCAL;
                                offset_next = address;
                            end
                            default:
                            begin
                                status_next = STAT_NOT_FOUND;
                                offset_next = '0;
                            end
                        endcase
                    end
                end
            end
            S_SCAN:
            begin
                // Issue one read a cycle, check the entry read the cycle before
                scan_idx_next = (scan_idx_reg == LAST_IDX) ? scan_idx_reg
                                                           : scan_idx_reg + 1'b1;
                chk_pend_next = 1'b1;
                chk_idx_next  = scan_idx_reg;
                if (chk_pend_reg && mres.hit)
                begin
                    found_next    = 1'b1;
                    hit_idx_next  = chk_idx_reg;
                    hit_size_next = rd_entry.size;
                    hit_off_next  = mres.offset;
                end
            end
            S_FINISH:
            begin
                done_next   = 1'b1;
                status_next = STAT_NOT_FOUND;
                slot_next   = '0;
                offset_next = '0;
                unique case (req_reg)
                    REQ_REGISTER:
                    begin
                        priority if (!found_reg)
                        begin
                            status_next = STAT_NO_SLOT;
                        end
                        else if (addr_reg == '0)
                        begin
                            status_next = STAT_ALLOC_FAIL;
                        end
                        else
                        begin
                            wr_en         = 1'b1;
                            wr_valid      = 1'b1;
                            wr_data.start = addr_reg;
                            wr_data.size  = asize_reg;
                            total_next    = total_reg + ADDR_W'(asize_reg);
                            recent_next   = addr_reg;
                            status_next   = STAT_OK;
                            slot_next     = SLOT_OUT_W'(hit_idx_reg);
                        end
                    end
                    REQ_RELEASE:
                    begin
                        if (found_reg)
                        begin
                            wr_en       = 1'b1;
                            wr_valid    = 1'b0;
                            total_next  = total_reg - ADDR_W'(hit_size_reg);
                            recent_next = '0;
                            status_next = STAT_OK;
                            slot_next   = SLOT_OUT_W'(hit_idx_reg);
                        end
                    end
                    REQ_LOOKUP:
                    begin
                        if (found_reg)
                        begin
                            status_next = STAT_OK;
                            slot_next   = SLOT_OUT_W'(hit_idx_reg);
                            offset_next = hit_off_reg;
                        end
                    end
                    default:
                    begin
                        status_next = STAT_NOT_FOUND;
                    end
                endcase
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            scan_idx_reg <= '0;
            chk_pend_reg <= 1'b0;
            chk_idx_reg  <= '0;
            found_reg    <= 1'b0;
            done_reg     <= 1'b0;
            total_reg    <= '0;
            recent_reg   <= '0;
            my_pe_reg    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_idx_reg <= scan_idx_next;
            chk_pend_reg <= chk_pend_next;
            chk_idx_reg  <= chk_idx_next;
            found_reg    <= found_next;
            done_reg     <= done_next;
            total_reg    <= total_next;
            recent_reg   <= recent_next;
            my_pe_reg    <= my_pe_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        addr_reg     <= addr_next;
        asize_reg    <= asize_next;
        hit_idx_reg  <= hit_idx_next;
        hit_size_reg <= hit_size_next;
        hit_off_reg  <= hit_off_next;
        status_reg   <= status_next;
        slot_reg     <= slot_next;
        offset_reg   <= offset_next;
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign slot_index   = slot_reg;
    assign offset       = offset_reg;
    assign aligned_size = asize_reg;
    assign shared_total = total_reg;
    assign last_start   = recent_reg;

`ifndef NO_ASSERTIONS
    // An accepted transaction either walks the table or answers next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (busy || done))
    else $error("accepted transaction neither scanning nor answered");

    // A result is only presented once the sequencer is back to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
    else $error("result strobe while still busy");

    // Finishing a walk always produces a result
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH) |=> done)
    else $error("walk finished without a result");

    // The running total only moves together with a result
    assert property (@(posedge clk) disable iff (!rst_n)
        !done |-> $stable(shared_total))
    else $error("running total changed without a result");
`endif

endmodule
